// File: design/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every clock edge outside reset.
`define PPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define PPS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/pps_pkg.sv
// Types and constants shared by the preemptive priority scheduler modules.
package pps_pkg;

    localparam int SLOT_W  = 4;
    localparam int TICK_W  = 16;
    localparam int BURST_W = 12;
    localparam int PRIO_W  = 8;
    localparam int SUM_W   = 20;
    localparam int DONE_W  = 5;
    localparam int CNT_W   = 5;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 96;
    localparam int OUT_USER_W = 2;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;
    localparam logic [DONE_W-1:0] DONE_MAX = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

    // Command kinds carried on s_tuser.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic [TICK_W-1:0]  arrival;
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] remaining;
        logic [PRIO_W-1:0]  prio;
    } task_entry_t;

    typedef struct packed {
        logic load_wr;
        logic tick_start;
        logic scan_rd;
        logic figure;
        logic commit;
        logic emit;
    } pps_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } pps_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FIGURE,
        ST_COMMIT,
        ST_EMIT
    } pps_state_t;

endpackage

// File: design/pps_ctrl.sv
// Sequencing state machine of the scheduler: load, slot scan, update and result.
`include "assert_macros.svh"

module pps_ctrl import pps_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,
    input  pps_status_t status_i,
    output pps_cmd_t    cmd_o
);

    pps_state_t state_reg;
    pps_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && (s_tuser == CMD_TICK)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status_i.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_FIGURE;
            ST_FIGURE: state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_EMIT;
            ST_EMIT: begin
                if (status_i.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd_o    = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready         = 1'b1;
                cmd_o.load_wr    = s_tvalid && (s_tuser == CMD_LOAD);
                cmd_o.tick_start = s_tvalid && (s_tuser == CMD_TICK);
            end
            ST_SCAN:   cmd_o.scan_rd = 1'b1;
            ST_DRAIN:  cmd_o = '0;
            ST_FIGURE: cmd_o.figure = 1'b1;
            ST_COMMIT: cmd_o.commit = 1'b1;
            ST_EMIT:   cmd_o.emit = status_i.out_free;
            default:   cmd_o = '0;
        endcase
    end

    `PPS_ASSERT(a_cmd_onehot, $onehot0({cmd_o.load_wr, cmd_o.tick_start, cmd_o.scan_rd, cmd_o.figure, cmd_o.commit, cmd_o.emit}), "more than one datapath command at once")
    `PPS_ASSERT_NEXT(a_tick_scans, cmd_o.tick_start, cmd_o.scan_rd, "tick word not followed by a slot scan")
    `PPS_ASSERT_NEXT(a_figure_commit, cmd_o.figure, cmd_o.commit, "update figures not committed")

endmodule

// File: design/pps_datapath.sv
// Task memory, slot scan comparator, completion arithmetic and result register.
`include "assert_macros.svh"

module pps_datapath import pps_pkg::*; #(
    parameter int MAX_TASKS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CNT_W-1:0]      cfg_data,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  pps_cmd_t              cmd_i,
    output pps_status_t           status_o,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = (IW + 1 > CNT_W) ? IW + 1 : CNT_W;
    localparam logic [CW-1:0] MAX_VAL = CW'(MAX_TASKS);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TASKS - 1);

    // Input word fields.
    logic [SLOT_W-1:0]  ld_slot;
    logic [TICK_W-1:0]  ld_arrival;
    logic [BURST_W-1:0] ld_burst;
    logic [PRIO_W-1:0]  ld_prio;

    assign ld_slot    = s_tdata[3:0];
    assign ld_arrival = s_tdata[19:4];
    assign ld_burst   = s_tdata[31:20];
    assign ld_prio    = s_tdata[39:32];

    task_entry_t mem [MAX_TASKS];
    task_entry_t rd_data_reg;

    logic [CNT_W-1:0]  task_count_reg;
    logic [IW-1:0]     scan_idx_reg;
    logic              rd_valid_reg;
    logic [IW-1:0]     rd_idx_reg;
    logic              found_reg;
    logic [IW-1:0]     best_idx_reg;
    task_entry_t       best_entry_reg;
    logic              fin_reg;
    logic [TICK_W-1:0] fin_t_reg;
    logic [TICK_W-1:0] tat_reg;
    logic [TICK_W-1:0] wt_reg;
    logic [TICK_W-1:0] tick_reg;
    logic [DONE_W-1:0] done_reg;
    logic [SUM_W-1:0]  wsum_reg;
    logic [SUM_W-1:0]  tsum_reg;
    logic              m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_USER_W-1:0] m_tuser_reg;

    logic [CW-1:0]     slot_ext;
    logic              load_ok;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    task_entry_t       wr_data;
    logic              take;
    logic [TICK_W-1:0] fin_t_now;
    logic [SUM_W:0]    tsum_wide;
    logic [SUM_W-1:0]  tsum_next;
    logic [SUM_W:0]    wsum_wide;
    logic [SUM_W-1:0]  wsum_next;
    logic [CW-1:0]     n_val;
    logic              all_done;
    logic [CW-1:0]     best_ext;
    logic [SLOT_W-1:0] ran_slot;
    logic              out_free;

    // Loads and the write-back of the decremented burst share one port.
    assign slot_ext = CW'(ld_slot);
    assign load_ok  = slot_ext < MAX_VAL;
    assign wr_en    = (cmd_i.load_wr && load_ok) || (cmd_i.figure && found_reg);
    assign wr_addr  = cmd_i.figure ? best_idx_reg : slot_ext[IW-1:0];

    always_comb begin
        if (cmd_i.figure) begin
            wr_data           = best_entry_reg;
            wr_data.remaining = best_entry_reg.remaining - 1'b1;
        end else begin
            wr_data.arrival   = ld_arrival;
            wr_data.burst     = ld_burst;
            wr_data.remaining = ld_burst;
            wr_data.prio      = ld_prio;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd_i.scan_rd) begin
            rd_data_reg <= mem[scan_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            task_count_reg <= CNT_W'(1);
        end else if (cfg_valid) begin
            task_count_reg <= cfg_data;
        end
    end

    // One slot is compared per cycle; strict less-than keeps the lowest slot on a tie.
    assign take = rd_valid_reg
               && (CW'(rd_idx_reg) < CW'(task_count_reg))
               && (rd_data_reg.arrival <= tick_reg)
               && (rd_data_reg.remaining != '0)
               && (!found_reg || (rd_data_reg.prio < best_entry_reg.prio));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end else begin
            rd_valid_reg <= cmd_i.scan_rd;
            if (cmd_i.tick_start) begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end else begin
                if (cmd_i.scan_rd) begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (take) begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.scan_rd) begin
            rd_idx_reg <= scan_idx_reg;
        end
        if (take) begin
            best_entry_reg <= rd_data_reg;
            best_idx_reg   <= rd_idx_reg;
        end
    end

    assign fin_t_now = (tick_reg == TICK_MAX) ? tick_reg : tick_reg + 1'b1;

    // The chosen task has already arrived, so the turnaround never goes negative.
    always_ff @(posedge aclk) begin
        if (cmd_i.figure) begin
            fin_reg   <= found_reg && (best_entry_reg.remaining == BURST_W'(1));
            fin_t_reg <= fin_t_now;
            tat_reg   <= fin_t_now - best_entry_reg.arrival;
        end
        if (cmd_i.commit) begin
            if (tat_reg > TICK_W'(best_entry_reg.burst)) begin
                wt_reg <= tat_reg - TICK_W'(best_entry_reg.burst);
            end else begin
                wt_reg <= '0;
            end
        end
    end

    assign tsum_wide = {1'b0, tsum_reg} + (SUM_W + 1)'(tat_reg);
    assign tsum_next = tsum_wide[SUM_W] ? SUM_MAX : tsum_wide[SUM_W-1:0];
    assign wsum_wide = {1'b0, wsum_reg} + (SUM_W + 1)'(wt_reg);
    assign wsum_next = !fin_reg ? wsum_reg
                     : (wsum_wide[SUM_W] ? SUM_MAX : wsum_wide[SUM_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= '0;
            done_reg <= '0;
            tsum_reg <= '0;
            wsum_reg <= '0;
        end else begin
            if (cmd_i.commit) begin
                tick_reg <= fin_t_now;
                if (fin_reg) begin
                    tsum_reg <= tsum_next;
                    if (done_reg != DONE_MAX) begin
                        done_reg <= done_reg + 1'b1;
                    end
                end
            end
            if (cmd_i.emit) begin
                wsum_reg <= wsum_next;
            end
        end
    end

    assign n_val    = (CW'(task_count_reg) < MAX_VAL) ? CW'(task_count_reg) : MAX_VAL;
    assign all_done = CW'(done_reg) >= n_val;
    assign best_ext = CW'(best_idx_reg);
    assign ran_slot = found_reg ? best_ext[SLOT_W-1:0] : '0;
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd_i.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.emit) begin
            m_tdata_reg <= {3'b000, all_done, tsum_reg, wsum_next,
                            fin_reg ? tat_reg : '0,
                            fin_reg ? wt_reg : '0,
                            fin_reg ? fin_t_reg : '0,
                            ran_slot};
            m_tuser_reg <= {fin_reg, !found_reg};
        end
    end

    assign status_o.scan_last = scan_idx_reg == LAST_IDX;
    assign status_o.out_free  = out_free;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `PPS_ASSERT_IMPL(a_emit_free, cmd_i.emit, out_free, "result register overwritten while still held")
    `PPS_ASSERT_IMPL(a_best_live, cmd_i.figure && found_reg, best_entry_reg.remaining != '0, "chosen task has no burst left")
    `PPS_ASSERT_IMPL(a_valid_from_emit, m_tvalid_reg && !$past(m_tvalid_reg), $past(cmd_i.emit), "result appeared without an emit command")

endmodule

// File: design/preemptive_priority_scheduler.sv
// A tick word runs the scan, drain, figure, commit and emit states, then gives one result;
// a load gives none. No word is taken until idle again; emit waits for a free result register.
// In idle one load word is taken per cycle; the scan reads one task-memory entry per cycle.
// Reset (aresetn, synchronous, active low) clears time, counts, sums and sets task_count to 1;
// task slots hold no defined value until loaded, and there is no clearing pass.
module preemptive_priority_scheduler import pps_pkg::*; #(
    parameter int MAX_TASKS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration: task_count.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CNT_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // slot, arrival_time, burst_length, task_priority
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // cmd
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // ran_slot, finish_time, waiting_time, turnaround_time, total_waiting,
    // total_turnaround, all_done, zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    // idle, finished
    output logic [OUT_USER_W-1:0] m_tuser
);

    pps_cmd_t    cmd;
    pps_status_t status;

    assign cfg_ready = 1'b1;

    pps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status_i (status),
        .cmd_o    (cmd)
    );

    pps_datapath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd_i     (cmd),
        .status_o  (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: tb/preemptive_priority_scheduler_checker.sv
// Checker for the priority scheduler: tracks the task table and compares every result word.
module preemptive_priority_scheduler_checker import pps_pkg::*; #(
    parameter int MAX_TASKS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CNT_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [OUT_USER_W-1:0] m_tuser,
    output int                    mismatches,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [SLOT_W-1:0] ran_slot;
        logic              idle;
        logic              finished;
        logic [TICK_W-1:0] finish_time;
        logic [TICK_W-1:0] waiting_time;
        logic [TICK_W-1:0] turnaround_time;
        logic [SUM_W-1:0]  total_waiting;
        logic [SUM_W-1:0]  total_turnaround;
        logic              all_done;
    } tick_report_t;

    task_entry_t        task_table [MAX_TASKS];
    logic [TICK_W-1:0]  now_tick;
    logic [DONE_W-1:0]  finished_count;
    logic [SUM_W-1:0]   wait_total;
    logic [SUM_W-1:0]   turnaround_total;
    logic [CNT_W-1:0]   task_count_q;
    tick_report_t       expected_reports [$];
    int                 words_checked;

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] result word %0d: %s", $realtime, words_checked, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    // One scheduler tick: pick the most urgent arrived task, run it, update the figures.
    function automatic tick_report_t schedule_tick();
        tick_report_t      rep;
        int unsigned       limit;
        int unsigned       pick;
        bit                found;
        logic [TICK_W-1:0] fin_t;
        logic [TICK_W-1:0] tat;
        logic [TICK_W-1:0] wt;
        logic [SUM_W:0]    sum;
        rep   = '0;
        limit = (task_count_q > MAX_TASKS) ? MAX_TASKS : task_count_q;
        found = 1'b0;
        pick  = 0;
        fin_t = '0;
        tat   = '0;
        wt    = '0;
        for (int i = 0; i < limit; i++) begin
            if (task_table[i].arrival <= now_tick && task_table[i].remaining != '0 &&
                (!found || task_table[i].prio < task_table[pick].prio)) begin
                pick  = i;
                found = 1'b1;
            end
        end
        if (found) begin
            task_table[pick].remaining = task_table[pick].remaining - 1'b1;
            if (task_table[pick].remaining == '0) begin
                rep.finished = 1'b1;
                fin_t = (now_tick != TICK_MAX) ? now_tick + 1'b1 : TICK_MAX;
                tat = (fin_t > task_table[pick].arrival) ?
                      fin_t - task_table[pick].arrival : '0;
                wt = (tat > TICK_W'(task_table[pick].burst)) ?
                     tat - TICK_W'(task_table[pick].burst) : '0;
                if (finished_count != DONE_MAX)
                    finished_count = finished_count + 1'b1;
                sum = {1'b0, wait_total} + wt;
                wait_total = (sum > SUM_MAX) ? SUM_MAX : sum[SUM_W-1:0];
                sum = {1'b0, turnaround_total} + tat;
                turnaround_total = (sum > SUM_MAX) ? SUM_MAX : sum[SUM_W-1:0];
            end
        end
        if (now_tick != TICK_MAX)
            now_tick = now_tick + 1'b1;
        rep.ran_slot         = found ? SLOT_W'(pick) : '0;
        rep.idle             = !found;
        rep.finish_time      = fin_t;
        rep.waiting_time     = wt;
        rep.turnaround_time  = tat;
        rep.total_waiting    = wait_total;
        rep.total_turnaround = turnaround_total;
        rep.all_done         = (finished_count >= limit);
        return rep;
    endfunction

    always @(posedge aclk) begin
        tick_report_t want;
        tick_report_t got;
        logic [SLOT_W-1:0] slot;
        if (!aresetn) begin
            for (int i = 0; i < MAX_TASKS; i++)
                task_table[i] = '0;
            now_tick         = '0;
            finished_count   = '0;
            wait_total       = '0;
            turnaround_total = '0;
            task_count_q     = CNT_W'(1);
            words_checked    = 0;
            expected_reports.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                task_count_q = cfg_data;
            // Results are taken before new ticks are predicted, so a word can never
            // be matched against a prediction made in the same cycle.
            if (m_tvalid && m_tready) begin
                got.ran_slot         = m_tdata[3:0];
                got.finish_time      = m_tdata[19:4];
                got.waiting_time     = m_tdata[35:20];
                got.turnaround_time  = m_tdata[51:36];
                got.total_waiting    = m_tdata[71:52];
                got.total_turnaround = m_tdata[91:72];
                got.all_done         = m_tdata[92];
                got.idle             = m_tuser[0];
                got.finished         = m_tuser[1];
                if (expected_reports.size() == 0) begin
                    report_mismatch("result word arrived with nothing expected");
                end else begin
                    want = expected_reports.pop_front();
                    check_field("ran_slot", got.ran_slot, want.ran_slot);
                    check_field("idle", got.idle, want.idle);
                    check_field("finished", got.finished, want.finished);
                    check_field("finish_time", got.finish_time, want.finish_time);
                    check_field("waiting_time", got.waiting_time, want.waiting_time);
                    check_field("turnaround_time", got.turnaround_time,
                                want.turnaround_time);
                    check_field("total_waiting", got.total_waiting, want.total_waiting);
                    check_field("total_turnaround", got.total_turnaround,
                                want.total_turnaround);
                    check_field("all_done", got.all_done, want.all_done);
                end
                words_checked++;
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_TICK) begin
                    expected_reports.push_back(schedule_tick());
                end else begin
                    slot = s_tdata[3:0];
                    if (slot < MAX_TASKS) begin
                        task_table[slot].arrival   = s_tdata[19:4];
                        task_table[slot].burst     = s_tdata[31:20];
                        task_table[slot].remaining = s_tdata[31:20];
                        task_table[slot].prio      = s_tdata[39:32];
                    end
                end
            end
        end
        outstanding <= expected_reports.size();
    end

endmodule

// File: tb/preemptive_priority_scheduler_tb.sv
// Top of the scheduler testbench: clock, reset, stimulus, result back-pressure and verdict.
module preemptive_priority_scheduler_tb import pps_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS     = 16;
    localparam int PHASE_WORDS   = 240;
    localparam int SETTLE_CYCLES = NUM_SLOTS + 10;
    // Longest quiet stretch is the long receiver hold plus a tick; this is well above it.
    localparam int STALL_LIMIT   = 4000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CNT_W-1:0]      cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = CMD_LOAD;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    int mismatches;
    int outstanding;
    int ticks_sent    = 0;
    int results_taken = 0;
    int stall_cycles  = 0;
    bit quiet         = 1'b0;

    always #10 aclk = ~aclk;

    preemptive_priority_scheduler #(.MAX_TASKS(NUM_SLOTS)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    preemptive_priority_scheduler_checker #(.MAX_TASKS(NUM_SLOTS)) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    task automatic write_task_count(input int unsigned count);
        cfg_valid <= 1'b1;
        cfg_data  <= CNT_W'(count);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_word(input logic cmd, input logic [IN_DATA_W-1:0] data);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_TICK)
            ticks_sent++;
    endtask

    task automatic load_slot(input int unsigned slot, input int unsigned arrival,
                             input int unsigned burst, input int unsigned prio);
        send_word(CMD_LOAD, {PRIO_W'(prio), BURST_W'(burst), TICK_W'(arrival),
                             SLOT_W'(slot)});
    endtask

    task automatic send_tick();
        logic [IN_DATA_W-1:0] junk;
        // The payload of a tick word is ignored, so it carries noise.
        junk[31:0]  = $urandom();
        junk[39:32] = 8'($urandom_range(0, 255));
        send_word(CMD_TICK, junk);
    endtask

    task automatic send_random_word();
        int unsigned arrival;
        int unsigned burst;
        int unsigned prio;
        int unsigned roll;
        if ($urandom_range(0, 99) < 30) begin
            // Most tasks arrive just ahead of the current time so that they compete.
            roll = $urandom_range(0, 99);
            if (roll < 70)
                arrival = ticks_sent + $urandom_range(0, 8);
            else if (roll < 85)
                arrival = $urandom_range(0, ticks_sent);
            else
                arrival = $urandom_range(0, 65535);
            if (arrival > 65535)
                arrival = 65535;
            roll = $urandom_range(0, 99);
            if (roll < 70)
                burst = $urandom_range(1, 6);
            else if (roll < 95)
                burst = $urandom_range(1, 60);
            else
                burst = $urandom_range(1, 4095);
            prio = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 255);
            load_slot($urandom_range(0, NUM_SLOTS - 1), arrival, burst, prio);
        end else begin
            send_tick();
        end
    endtask

    // Lets every expected result drain, then gives the block time to finish any work.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int unsigned task_count_plan [8];
        task_count_plan = '{1, 0, 31, 17, 5, 16, 0, 16};
        task_count_plan[6] = $urandom_range(1, 16);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_task_count(16);

        // Every slot is loaded before the first tick so no unwritten entry is ever scanned.
        load_slot(0, 0, 2, 5);
        load_slot(1, 0, 1, 5);          // ties with slot 0, which must win
        load_slot(2, 0, 0, 0);          // zero burst: never runs
        load_slot(3, 65535, 4095, 0);   // arrives at the end of time
        load_slot(4, 1, 1, 0);          // preempts at the second tick
        for (int s = 5; s < NUM_SLOTS - 1; s++)
            load_slot(s, 3, 1 + s % 3, 200 - s);
        load_slot(NUM_SLOTS - 1, 0, 4095, 255);
        repeat (8) send_tick();

        for (int phase = 0; phase < 8; phase++) begin
            settle();
            if (phase == 7)
                quiet = 1'b1;
            write_task_count(task_count_plan[phase]);
            repeat (PHASE_WORDS) send_random_word();
        end
        settle();

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold that fills the block up.
    initial begin
        bit          held;
        int unsigned span;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (quiet || $urandom_range(0, 3) != 0) begin
                m_tready <= 1'b1;
                span = $urandom_range(1, 20);
            end else begin
                m_tready <= 1'b0;
                span = $urandom_range(1, 12);
            end
            repeat (span) @(posedge aclk);
            if (!held && !quiet && results_taken >= 300) begin
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
                held = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready)
            results_taken <= results_taken + 1;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[%0t] no word moved for %0d cycles", $realtime, STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
